FILE: design/xor_checked_sentence_deframer_core_assert.svh
// Assertion macros for the sentence deframer; empty when synthesizing.
`ifndef XOR_CHECKED_SENTENCE_DEFRAMER_CORE_ASSERT_SVH
`define XOR_CHECKED_SENTENCE_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define XCSD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("deframer check failed: same-cycle implication");

// Next-cycle implication.
`define XCSD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("deframer check failed: next-cycle implication");

`else

`define XCSD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define XCSD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

FILE: design/xcsd_pkg.sv
// Types and constants for the XOR-checked sentence deframer.
`timescale 1ns / 1ps
`default_nettype none

package xcsd_pkg;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_SUM     = 2'd2
  } phase_t;

  typedef logic [2:0] event_kind_t;

  localparam event_kind_t EV_NONE  = 3'd0;
  localparam event_kind_t EV_ERROR = 3'd1;
  localparam event_kind_t EV_CHA   = 3'd2;
  localparam event_kind_t EV_ACC   = 3'd3;
  localparam event_kind_t EV_REV   = 3'd4;
  localparam event_kind_t EV_SHO   = 3'd5;
  localparam event_kind_t EV_RES   = 3'd6;

  localparam logic [7:0] CH_START   = 8'h24;  // '$'
  localparam logic [7:0] CH_STAR    = 8'h2A;  // '*'
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_F = 8'd70;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

  localparam logic [23:0] TYPE_CHA = "CHA";
  localparam logic [23:0] TYPE_ACC = "ACC";
  localparam logic [23:0] TYPE_REV = "REV";
  localparam logic [23:0] TYPE_SHO = "SHO";
  localparam logic [23:0] TYPE_RES = "RES";

endpackage

`default_nettype wire

FILE: design/xor_checked_sentence_deframer_core.sv
// Top level: byte-stream deframer for $payload*HH sentences with XOR checksum.
// Path: an accepted byte is captured in the input register and decoded from there; its
//   result item is then registered in the result register, from which it can be taken.
// Throughput: one byte per cycle; the input register stalls only while a
//   pending result is not taken and the next byte also produces a result.
// Reset (rst, synchronous): waiting for '$', all sentence state clear, no result valid.
`timescale 1ns / 1ps
`default_nettype none

`include "xor_checked_sentence_deframer_core_assert.svh"

module xor_checked_sentence_deframer_core
  import xcsd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [3:0] digit_a, [7:4] digit_b, [11:8] digit_c
  output logic [2:0]       m_axis_tuser    // [2:0] event_kind
);

  localparam logic [7:0] MaxCount = 8'(MAX_PAYLOAD);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // sentence state
  phase_t     phase, phase_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] type_letters [3];
  logic [7:0] type_letters_next [3];
  logic [3:0] param_digits [3];
  logic [3:0] param_digits_next [3];
  logic [1:0] field_count, field_count_next;
  logic       format_bad, format_bad_next;
  logic [1:0] hex_count, hex_count_next;
  logic [7:0] received_sum, received_sum_next;

  // decode results
  logic        emit;
  event_kind_t ev_kind;
  logic [3:0]  ev_a, ev_b, ev_c;
  logic        do_clear;
  logic        step;

  event_kind_t type_kind;
  logic [1:0]  need;
  logic [7:0]  need_len;
  logic [7:0]  hex_diff;
  logic [3:0]  hex_val;
  logic [23:0] letters;

  assign step          = in_valid && (!emit || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  // type lookup
  always_comb begin
    letters = {type_letters[0], type_letters[1], type_letters[2]};
    case (letters)
      TYPE_CHA: begin type_kind = EV_CHA; need = 2'd1; need_len = 8'd5; end
      TYPE_ACC: begin type_kind = EV_ACC; need = 2'd1; need_len = 8'd5; end
      TYPE_REV: begin type_kind = EV_REV; need = 2'd1; need_len = 8'd5; end
      TYPE_SHO: begin type_kind = EV_SHO; need = 2'd2; need_len = 8'd7; end
      TYPE_RES: begin type_kind = EV_RES; need = 2'd3; need_len = 8'd9; end
      default:  begin type_kind = EV_NONE; need = 2'd0; need_len = 8'd3; end
    endcase
  end

  always_comb begin
    phase_next         = phase;
    payload_count_next = payload_count;
    running_xor_next   = running_xor;
    field_count_next   = field_count;
    format_bad_next    = format_bad;
    hex_count_next     = hex_count;
    received_sum_next  = received_sum;
    for (int i = 0; i < 3; i++) begin
      type_letters_next[i] = type_letters[i];
      param_digits_next[i] = param_digits[i];
    end
    emit     = 1'b0;
    ev_kind  = EV_ERROR;
    ev_a     = 4'd0;
    ev_b     = 4'd0;
    ev_c     = 4'd0;
    do_clear = 1'b0;
    hex_diff = in_byte - CH_ZERO;
    hex_val  = 4'd0;

    if (in_byte == CH_NEWLINE) begin
      emit       = 1'b1;
      do_clear   = 1'b1;
      phase_next = PH_WAIT;
      if (phase == PH_SUM && type_kind != EV_NONE && !format_bad &&
          payload_count == need_len && field_count == need &&
          hex_count == 2'd2 && received_sum == running_xor) begin
        ev_kind = type_kind;
        ev_a    = param_digits[0];
        ev_b    = (need >= 2'd2) ? param_digits[1] : 4'd0;
        ev_c    = (need == 2'd3) ? param_digits[2] : 4'd0;
      end
    end else begin
      case (phase)
        PH_PAYLOAD: begin
          if (in_byte == CH_START || (in_byte != CH_STAR && payload_count >= MaxCount)) begin
            emit       = 1'b1;
            do_clear   = 1'b1;
            phase_next = PH_WAIT;
          end else if (in_byte == CH_STAR) begin
            phase_next = PH_SUM;
          end else begin
            running_xor_next   = running_xor ^ in_byte;
            payload_count_next = payload_count + 8'd1;
            if (payload_count < 8'd3) begin
              type_letters_next[payload_count[1:0]] = in_byte;
            end else if (payload_count > 8'd8) begin
              format_bad_next = 1'b1;
            end else if (payload_count[0]) begin
              // positions 3, 5, 7 hold the separators
              if (in_byte != CH_COMMA) format_bad_next = 1'b1;
            end else if (in_byte inside {[CH_ZERO:CH_NINE]}) begin
              if (field_count != 2'd3) begin
                param_digits_next[field_count] = hex_diff[3:0];
                field_count_next = field_count + 2'd1;
              end
            end else begin
              format_bad_next = 1'b1;
            end
          end
        end
        PH_SUM: begin
          if (in_byte inside {[CH_ZERO:CH_NINE]}) begin
            hex_val = hex_diff[3:0];
          end else begin
            hex_diff = in_byte - HEX_ALPHA_OFS;
            hex_val  = hex_diff[3:0];
          end
          if (hex_count >= 2'd2 ||
              !(in_byte inside {[CH_ZERO:CH_NINE], [CH_UPPER_A:CH_UPPER_F]})) begin
            emit       = 1'b1;
            do_clear   = 1'b1;
            phase_next = PH_WAIT;
          end else begin
            received_sum_next = {received_sum[3:0], hex_val};
            hex_count_next    = hex_count + 2'd1;
          end
        end
        default: begin
          if (in_byte == CH_START) begin
            do_clear   = 1'b1;
            phase_next = PH_PAYLOAD;
          end else begin
            phase_next = PH_WAIT;
          end
        end
      endcase
    end

    if (do_clear) begin
      payload_count_next = 8'd0;
      running_xor_next   = 8'd0;
      field_count_next   = 2'd0;
      format_bad_next    = 1'b0;
      hex_count_next     = 2'd0;
      received_sum_next  = 8'd0;
      for (int i = 0; i < 3; i++) begin
        type_letters_next[i] = 8'd0;
        param_digits_next[i] = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      payload_count <= 8'd0;
      running_xor   <= 8'd0;
      field_count   <= 2'd0;
      format_bad    <= 1'b0;
      hex_count     <= 2'd0;
      received_sum  <= 8'd0;
      for (int i = 0; i < 3; i++) begin
        type_letters[i] <= 8'd0;
        param_digits[i] <= 4'd0;
      end
    end else if (step) begin
      phase         <= phase_next;
      payload_count <= payload_count_next;
      running_xor   <= running_xor_next;
      field_count   <= field_count_next;
      format_bad    <= format_bad_next;
      hex_count     <= hex_count_next;
      received_sum  <= received_sum_next;
      for (int i = 0; i < 3; i++) begin
        type_letters[i] <= type_letters_next[i];
        param_digits[i] <= param_digits_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (step && emit) begin
      m_axis_tuser <= ev_kind;
      m_axis_tdata <= {4'd0, ev_c, ev_b, ev_a};
    end
  end

  `XCSD_ASSERT_IMP(a_no_overwrite, clk, rst, step && emit && m_axis_tvalid, m_axis_tready)
  `XCSD_ASSERT_IMP(a_wait_is_clear, clk, rst, phase == PH_WAIT, payload_count == 8'd0 && hex_count == 2'd0)
  `XCSD_ASSERT_IMP(a_count_bound, clk, rst, phase != PH_WAIT, payload_count <= MaxCount)
  `XCSD_ASSERT_NXT(a_drain, clk, rst, m_axis_tvalid && m_axis_tready && !(step && emit), !m_axis_tvalid)
  `XCSD_ASSERT_IMP(a_hex_only_in_sum, clk, rst, hex_count != 2'd0, phase == PH_SUM)

endmodule

`default_nettype wire

FILE: sim/xcsd_sentence_checker.sv
// Checker for the sentence deframer: watches both streams, predicts result items, compares.
`timescale 1ns / 1ps

module xcsd_sentence_checker
  import xcsd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,   // [3:0] digit_a, [7:4] digit_b, [11:8] digit_c
  input  wire logic [2:0]  m_axis_tuser,   // [2:0] event_kind
  output int               mismatches,
  output int               pending_results
);

  typedef struct packed {
    event_kind_t kind;
    logic [3:0]  digit_a;
    logic [3:0]  digit_b;
    logic [3:0]  digit_c;
  } sentence_event_t;

  sentence_event_t expected_events[$];
  int              fail_count = 0;

  // predictor copy of the deframer state
  phase_t     phase_q;
  logic [7:0] payload_len;
  logic [7:0] payload_xor;
  logic [7:0] type_letters[3];
  logic [3:0] param_digits[3];
  logic [1:0] digit_count;
  logic       layout_bad;
  logic [1:0] hex_count;
  logic [7:0] sum_field;

  task automatic clear_sentence();
    payload_len = '0;
    payload_xor = '0;
    for (int i = 0; i < 3; i++) begin
      type_letters[i] = '0;
      param_digits[i] = '0;
    end
    digit_count = '0;
    layout_bad  = 1'b0;
    hex_count   = '0;
    sum_field   = '0;
  endtask

  task automatic finish_sentence(input event_kind_t kind, input logic [3:0] a,
                                 input logic [3:0] b, input logic [3:0] c);
    sentence_event_t ev;
    ev.kind    = kind;
    ev.digit_a = a;
    ev.digit_b = b;
    ev.digit_c = c;
    expected_events.push_back(ev);
    phase_q = PH_WAIT;
    clear_sentence();
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int          pos;
    int          need;
    event_kind_t kind;
    logic [7:0]  nib;
    logic [23:0] letters;
    if (b == CH_NEWLINE) begin
      kind    = EV_NONE;
      need    = 0;
      letters = {type_letters[0], type_letters[1], type_letters[2]};
      case (letters)
        TYPE_CHA: begin kind = EV_CHA; need = 1; end
        TYPE_ACC: begin kind = EV_ACC; need = 1; end
        TYPE_REV: begin kind = EV_REV; need = 1; end
        TYPE_SHO: begin kind = EV_SHO; need = 2; end
        TYPE_RES: begin kind = EV_RES; need = 3; end
        default: ;
      endcase
      if (phase_q == PH_SUM && kind != EV_NONE && !layout_bad &&
          payload_len == 3 + 2 * need && digit_count == need &&
          hex_count == 2 && sum_field == payload_xor)
        finish_sentence(kind, param_digits[0],
                        (need >= 2) ? param_digits[1] : 4'd0,
                        (need >= 3) ? param_digits[2] : 4'd0);
      else
        finish_sentence(EV_ERROR, 4'd0, 4'd0, 4'd0);
    end else if (phase_q == PH_PAYLOAD) begin
      if (b == CH_START) begin
        finish_sentence(EV_ERROR, 4'd0, 4'd0, 4'd0);
      end else if (b == CH_STAR) begin
        phase_q = PH_SUM;
      end else if (payload_len >= MAX_PAYLOAD) begin
        finish_sentence(EV_ERROR, 4'd0, 4'd0, 4'd0);
      end else begin
        pos = int'(payload_len);
        payload_xor ^= b;
        if (pos < 3) begin
          type_letters[pos[1:0]] = b;
        end else if (pos > 8) begin
          layout_bad = 1'b1;
        end else if (((pos - 3) % 2) == 0) begin
          // comma slot
          if (b != CH_COMMA) layout_bad = 1'b1;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          if (digit_count < 3) begin
            nib = b - CH_ZERO;
            param_digits[digit_count] = nib[3:0];
            digit_count++;
          end
        end else begin
          layout_bad = 1'b1;
        end
        payload_len++;
      end
    end else if (phase_q == PH_SUM) begin
      if (hex_count >= 2) begin
        finish_sentence(EV_ERROR, 4'd0, 4'd0, 4'd0);
      end else if ((b >= CH_ZERO && b <= CH_NINE) || (b >= CH_UPPER_A && b <= CH_UPPER_F)) begin
        nib = (b <= CH_NINE) ? b - CH_ZERO : b - HEX_ALPHA_OFS;
        sum_field = {sum_field[3:0], nib[3:0]};
        hex_count++;
      end else begin
        finish_sentence(EV_ERROR, 4'd0, 4'd0, 4'd0);
      end
    end else if (b == CH_START) begin
      clear_sentence();
      phase_q = PH_PAYLOAD;
    end
  endtask

  task automatic report(input string what, input sentence_event_t exp,
                        input sentence_event_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected kind %0d digits %0d %0d %0d, got kind %0d digits %0d %0d %0d",
               $realtime, what, exp.kind, exp.digit_a, exp.digit_b, exp.digit_c,
               got.kind, got.digit_a, got.digit_b, got.digit_c);
  endtask

  always @(posedge clk) begin : watch
    sentence_event_t got;
    sentence_event_t exp;
    if (rst) begin
      phase_q = PH_WAIT;
      clear_sentence();
      expected_events.delete();
    end else begin
      // a result can never stem from the byte taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[7:4], m_axis_tdata[11:8]};
        if (expected_events.size() == 0) begin
          report("unexpected result item", '0, got);
        end else begin
          exp = expected_events.pop_front();
          if (got !== exp) report("result mismatch", exp, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata);
    end
    mismatches      <= fail_count;
    pending_results <= expected_events.size();
  end

endmodule

FILE: sim/xor_checked_sentence_deframer_core_test.sv
// Testbench top for the sentence deframer: byte stimulus, output stalls, verdict.
`timescale 1ns / 1ps

module xor_checked_sentence_deframer_core_test;
  import xcsd_pkg::*;

  localparam int MAX_PAYLOAD  = 128;
  localparam int STIM_BYTES   = 1200;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_SUM,
    FLAW_LOWER_HEX,
    FLAW_ONE_HEX,
    FLAW_THREE_HEX,
    FLAW_BAD_TYPE,
    FLAW_FIELD_COUNT,
    FLAW_BAD_DIGIT,
    FLAW_BAD_COMMA,
    FLAW_STRAY_BYTE,
    FLAW_START_INSIDE,
    FLAW_NEWLINE_INSIDE,
    FLAW_NO_NEWLINE,
    FLAW_LONG_PAYLOAD,
    FLAW_LAST
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  int mismatches;
  int pending_results;
  int sent_count  = 0;
  int cycle_count = 0;

  logic [7:0] tx_bytes[$];

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  xor_checked_sentence_deframer_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  xcsd_sentence_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .mismatches(mismatches),
    .pending_results(pending_results)
  );

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 10) ? CH_ZERO + v : CH_UPPER_A + v - 8'd10;
  endfunction

  // any byte except the three framing characters
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_START || b == CH_STAR || b == CH_NEWLINE);
    return b;
  endfunction

  task automatic add_sentence(input flaw_t flaw, input int kind_sel);
    logic [7:0]  payload[$];
    logic [7:0]  line[$];
    logic [23:0] name;
    logic [7:0]  sum;
    logic [7:0]  hi;
    logic [7:0]  lo;
    int          groups;
    int          len;
    case (kind_sel)
      0:       begin name = TYPE_CHA; groups = 1; end
      1:       begin name = TYPE_ACC; groups = 1; end
      2:       begin name = TYPE_REV; groups = 1; end
      3:       begin name = TYPE_SHO; groups = 2; end
      default: begin name = TYPE_RES; groups = 3; end
    endcase
    if (flaw == FLAW_BAD_TYPE)
      name[$urandom_range(0, 2) * 8 +: 8] = CH_UPPER_A + 8'($urandom_range(0, 25));
    if (flaw == FLAW_FIELD_COUNT)
      groups = ($urandom_range(0, 1) != 0 || groups == 3) ? groups - 1 : groups + 1;
    payload.push_back(name[23:16]);
    payload.push_back(name[15:8]);
    payload.push_back(name[7:0]);
    for (int i = 0; i < groups; i++) begin
      payload.push_back(CH_COMMA);
      payload.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if (flaw == FLAW_BAD_DIGIT) payload[4] = 8'($urandom);
    if (flaw == FLAW_BAD_COMMA) payload[3] = 8'($urandom);
    if (flaw == FLAW_LONG_PAYLOAD) begin
      // around the overflow edge: one byte short, fits exactly, or one byte too many
      len = MAX_PAYLOAD + $urandom_range(0, 1) - (($urandom_range(0, 3) == 0) ? 1 : 0);
      while (payload.size() < len) payload.push_back(plain_byte());
    end
    if (flaw == FLAW_START_INSIDE)
      payload.insert($urandom_range(0, payload.size()), CH_START);
    if (flaw == FLAW_NEWLINE_INSIDE)
      payload.insert($urandom_range(0, payload.size()), CH_NEWLINE);
    sum = '0;
    foreach (payload[i]) sum ^= payload[i];
    if (flaw == FLAW_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
    hi = hex_char(sum[7:4]);
    lo = hex_char(sum[3:0]);
    if (flaw == FLAW_LOWER_HEX) begin
      if (hi >= CH_UPPER_A) hi += 8'd32;
      else if (lo >= CH_UPPER_A) lo += 8'd32;
      else hi = 8'h61 + 8'($urandom_range(0, 5));
    end
    line.push_back(CH_START);
    foreach (payload[i]) line.push_back(payload[i]);
    line.push_back(CH_STAR);
    line.push_back(hi);
    if (flaw != FLAW_ONE_HEX) line.push_back(lo);
    if (flaw == FLAW_THREE_HEX) line.push_back(hex_char(4'($urandom_range(0, 15))));
    if (flaw != FLAW_NO_NEWLINE) line.push_back(CH_NEWLINE);
    if (flaw == FLAW_STRAY_BYTE)
      line.insert($urandom_range(1, line.size() - 1), 8'($urandom));
    foreach (line[i]) tx_bytes.push_back(line[i]);
  endtask

  task automatic build_stimulus();
    flaw_t flaw;
    // directed: extreme bytes while idle, newline with no sentence, every type, then flawed sentences
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(CH_NEWLINE);
    for (int k = 0; k < 5; k++) add_sentence(FLAW_NONE, k);
    add_sentence(FLAW_LOWER_HEX, 0);
    add_sentence(FLAW_BAD_SUM, 4);
    add_sentence(FLAW_THREE_HEX, 3);
    add_sentence(FLAW_ONE_HEX, 1);
    add_sentence(FLAW_START_INSIDE, 2);
    add_sentence(FLAW_NEWLINE_INSIDE, 4);
    add_sentence(FLAW_LONG_PAYLOAD, 0);
    // random: mostly clean sentences, the rest broken ones and line noise
    while (tx_bytes.size() < STIM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom));
      end
      if ($urandom_range(0, 99) < 55) begin
        flaw = FLAW_NONE;
      end else begin
        flaw = flaw_t'($urandom_range(FLAW_BAD_SUM, FLAW_LAST - 1));
        if (flaw == FLAW_LONG_PAYLOAD && $urandom_range(0, 2) != 0) flaw = FLAW_BAD_SUM;
      end
      add_sentence(flaw, $urandom_range(0, 4));
    end
  endtask

  // receiver: stall pattern changes from slot to slot of random length, plus one long hold
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  slot_left = 0;
  int  stall_mode = 0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= HOLD_AFTER) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      if (slot_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        slot_left <= $urandom_range(16, 80);
      end else begin
        slot_left <= slot_left - 1;
      end
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int burst;
    int gap;
    build_stimulus();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (tx_bytes.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && tx_bytes.size() > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tx_bytes.pop_front();
        do @(posedge clk); while (!s_axis_tready);
        sent_count++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    // the checker's counters are assigned nonblocking, so they lag behind the edge
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/xcsd_pkg.sv
design/xor_checked_sentence_deframer_core.sv
sim/xcsd_sentence_checker.sv
sim/xor_checked_sentence_deframer_core_test.sv
